FILE: hdl/kstc_pkg.sv
package kstc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 64;
  localparam int STATUS_W    = 3;
  localparam int FUNC_W      = 3;

  // request operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT_INIT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT_GIVEN = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CAS_UPDATE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CAS_REMOVE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE       = 3'd4;
  localparam logic [FUNC_W-1:0] FN_GET          = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLOSE        = 3'd6;

  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INITIALIZED = 3'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    peer_key;
    logic [STATUS_W-1:0] expected_status;
    logic [STATUS_W-1:0] new_status;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [STATUS_W-1:0] seen_status;
    logic                table_full;
  } rsp_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic                active;
    logic                hit;
    logic [STATUS_W-1:0] hit_status;
    logic                free;
  } carry_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic                en;
    logic                set_valid;
    logic                clr_valid;
    logic                wr_status;
    logic                clear_all;
    logic [STATUS_W-1:0] status;
  } cmd_t;

endpackage

FILE: hdl/kstc_cell.sv
module kstc_cell
  import kstc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX     = 0,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [KEY_W-1:0] req_key,
  input  carry_t           carry_in,
  input  logic [IDX_W-1:0] hit_idx_in,
  input  logic [IDX_W-1:0] free_idx_in,
  output carry_t           carry_out,
  output logic [IDX_W-1:0] hit_idx_out,
  output logic [IDX_W-1:0] free_idx_out,
  input  cmd_t             cmd,
  input  logic [IDX_W-1:0] cmd_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                valid;
  logic [KEY_W-1:0]    key;
  logic [STATUS_W-1:0] status;

  logic   match;
  logic   sel;
  carry_t carry_next;

  assign match = valid && (key == req_key);
  assign sel   = cmd.en && (cmd_idx == MY_IDX);

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.hit && match) begin
      carry_next.hit        = 1'b1;
      carry_next.hit_status = status;
    end
    if (!carry_in.free && !valid) begin
      carry_next.free = 1'b1;
    end
  end

  // scan stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
    hit_idx_out  <= (!carry_in.hit && match) ? MY_IDX : hit_idx_in;
    free_idx_out <= (!carry_in.free && !valid) ? MY_IDX : free_idx_in;
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.en && cmd.clear_all) begin
      valid <= 1'b0;
    end else if (sel && cmd.set_valid) begin
      valid <= 1'b1;
    end else if (sel && cmd.clr_valid) begin
      valid <= 1'b0;
    end
    if (sel && cmd.set_valid) begin
      key <= req_key;
    end
    if (sel && cmd.wr_status) begin
      status <= cmd.status;
    end
  end

endmodule

FILE: hdl/kstc_ctrl.sv
module kstc_ctrl
  import kstc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  output logic [KEY_W-1:0] req_key,
  output carry_t           launch,
  input  carry_t           carry_last,
  input  logic [IDX_W-1:0] hit_idx_last,
  input  logic [IDX_W-1:0] free_idx_last,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] cmd_idx
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t              state;
  req_t                req;
  logic                closed;
  logic                hit;
  logic [STATUS_W-1:0] hit_status;
  logic                free;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;
  logic                start;

  rsp_t                rsp_next;
  logic                out_free;
  logic                finish;
  logic [STATUS_W-1:0] desired;

  assign in_ready = (state == S_IDLE);
  assign req_key  = req.peer_key;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_DECIDE) && out_free;
  assign desired  = (req.func == FN_INSERT_INIT) ? ST_INITIALIZED : req.new_status;

  always_comb begin
    launch        = '0;
    launch.active = start;
  end

  always_comb begin
    rsp_next = '0;
    cmd      = '0;
    cmd_idx  = hit_idx;
    case (req.func)
      FN_INSERT_INIT, FN_INSERT_GIVEN: begin
        if (!closed) begin
          if (hit) begin
            rsp_next.seen_status = hit_status;
          end else if (!free) begin
            rsp_next.table_full = 1'b1;
          end else begin
            cmd.set_valid        = 1'b1;
            cmd.wr_status        = 1'b1;
            cmd.status           = desired;
            cmd_idx              = free_idx;
            rsp_next.ok          = 1'b1;
            rsp_next.seen_status = desired;
          end
        end
      end
      FN_CAS_UPDATE, FN_CAS_REMOVE: begin
        if (!closed && hit) begin
          if (hit_status == req.expected_status) begin
            if (req.func == FN_CAS_UPDATE) begin
              cmd.wr_status = 1'b1;
              cmd.status    = req.new_status;
            end else begin
              cmd.clr_valid = 1'b1;
            end
            rsp_next.ok          = 1'b1;
            rsp_next.seen_status = req.expected_status;
          end else begin
            rsp_next.seen_status = hit_status;
          end
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          cmd.clr_valid        = 1'b1;
          rsp_next.ok          = 1'b1;
          rsp_next.seen_status = hit_status;
        end
      end
      FN_GET: begin
        if (hit) begin
          rsp_next.seen_status = hit_status;
        end
      end
      FN_CLOSE: begin
        cmd.clear_all = 1'b1;
      end
      default: begin
      end
    endcase
    cmd.en = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= 1'b0;
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= in_valid && (state == S_IDLE);
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (carry_last.active) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (req.func == FN_CLOSE) begin
              closed <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (state == S_SCAN && carry_last.active) begin
      hit        <= carry_last.hit;
      hit_status <= carry_last.hit_status;
      free       <= carry_last.free;
      hit_idx    <= hit_idx_last;
      free_idx   <= free_idx_last;
    end
    if (finish) begin
      out_data <= rsp_next;
    end
  end

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    carry_last.active |-> state == S_SCAN)
    else $error("scan token left the chain outside a scan");

  a_accept_launches: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> start && state == S_SCAN)
    else $error("accepted transaction did not launch a scan");

  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.set_valid, cmd.clr_valid, cmd.clear_all}))
    else $error("conflicting entry write command");

  a_full_not_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.ok && out_data.table_full))
    else $error("full flag on a successful transaction");

  a_closed_no_insert: assert property (@(posedge clk) disable iff (rst)
    closed |-> !(cmd.en && cmd.set_valid))
    else $error("insert into a closed table");

endmodule

FILE: hdl/keyed_status_table_cas_top.sv
// channel | signals                        | payload
// in      | in_valid / in_ready            | in_data  : req_t (func, key, expected, new)
// out     | out_valid / out_ready          | out_data : rsp_t (ok, seen_status, full)
//
// after acceptance, the lookup token walks the chain of entry cells, one cell
// per cycle; the scan result is registered, then decided into the output register.
// one transaction is in flight at a time; the next is taken once the
// result is loaded into the output register, even if that result is stalled.
// a stalled output holds the finished transaction in its decide state.
// synchronous reset empties the table and reopens it.
module keyed_status_table_cas_top
  import kstc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [KEY_W-1:0] req_key;
  cmd_t             cmd;
  logic [IDX_W-1:0] cmd_idx;
  carry_t           carry [ENTRIES+1];
  logic [IDX_W-1:0] hit_idx [ENTRIES+1];
  logic [IDX_W-1:0] free_idx [ENTRIES+1];

  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  kstc_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .req_key      (req_key),
    .launch       (carry[0]),
    .carry_last   (carry[ENTRIES]),
    .hit_idx_last (hit_idx[ENTRIES]),
    .free_idx_last(free_idx[ENTRIES]),
    .cmd          (cmd),
    .cmd_idx      (cmd_idx)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kstc_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .req_key     (req_key),
      .carry_in    (carry[i]),
      .hit_idx_in  (hit_idx[i]),
      .free_idx_in (free_idx[i]),
      .carry_out   (carry[i+1]),
      .hit_idx_out (hit_idx[i+1]),
      .free_idx_out(free_idx[i+1]),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx)
    );
  end

endmodule
